// ===== rtl/bme_pkg.sv =====
package bme_pkg;

   localparam int PIX_W    = 8;
   localparam int CFG_W    = 11;
   localparam int AREA_W   = 21;
   localparam int CENT_W   = 18;
   localparam int VAR_W    = 47;
   localparam int XVAR_W   = 48;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

   // Quantities computed one after another at the end of a frame.
   typedef enum logic [2:0] {
      OP_CROW,
      OP_CCOL,
      OP_RVAR,
      OP_CVAR,
      OP_XVAR
   } op_type;

   typedef struct packed {
      logic   accum;
      logic   clear;
      logic   mul;
      logic   div_start;
      logic   store;
      logic   store_empty;
      logic   out_load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic area_zero;
      logic div_done;
      logic out_full;
   } sts_type;

endpackage

// ===== rtl/bme_divider.sv =====
module bme_divider #(
   parameter int DW = 70,
   parameter int VW = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic          rem_nz
);

   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   quo_ff, quo_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [VW:0]     shifted;
   logic [VW+1:0]   diff;
   logic            ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      ge      = !diff[VW+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNTW'(DW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[VW-1:0] : shifted[VW-1:0];
         quo_in  = {quo_ff[DW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = |rem_ff;

endmodule

// ===== rtl/bme_datapath.sv =====
module bme_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bme_pkg::cmd_type            cmd,
   output bme_pkg::sts_type            sts,
   input  logic [bme_pkg::PIX_W-1:0]   pixel,
   input  logic                        csr_valid,
   input  logic [bme_pkg::CFG_W-1:0]   csr_image_width,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [bme_pkg::AREA_W-1:0]  rsp_area,
   output logic [bme_pkg::CENT_W-1:0]  rsp_centroid_row_q8,
   output logic [bme_pkg::CENT_W-1:0]  rsp_centroid_col_q8,
   output logic [bme_pkg::VAR_W-1:0]   rsp_row_central_q8,
   output logic [bme_pkg::VAR_W-1:0]   rsp_col_central_q8,
   output logic signed [bme_pkg::XVAR_W-1:0] rsp_cross_central_q8,
   output logic                        rsp_empty_blob
);

   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int RW       = $clog2(MAX_HEIGHT);
   localparam int AREA_MAX = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW       = $clog2(AREA_MAX + 1);
   localparam int RSW      = AW + RW;
   localparam int CSW      = AW + CW;
   localparam int SW       = (RSW > CSW) ? RSW : CSW;
   localparam int PW       = 2 * SW;
   localparam int DW       = PW + 8;
   localparam int XW       = bme_pkg::XVAR_W;

   logic [bme_pkg::CFG_W-1:0] width_ff;
   logic [CW-1:0]          col_ff;
   logic [RW-1:0]          row_ff;
   logic [AW-1:0]          area_ff;
   logic [RSW-1:0]         rs_ff;
   logic [CSW-1:0]         cs_ff;
   logic [AW+2*RW-1:0]     rsq_ff;
   logic [AW+2*CW-1:0]     csq_ff;
   logic [AW+RW+CW-1:0]    xs_ff;
   logic [PW-1:0]          prod_ff;
   logic [CW:0]            eff_w;
   logic                   obj;
   logic [SW-1:0]          a_op, b_op;
   logic [DW-1:0]          dividend;
   logic                   div_done, rem_nz;
   logic [DW-1:0]          quot;
   logic [XW-1:0]          base, ceilq, diff;

   logic [bme_pkg::CENT_W-1:0] crow_ff, ccol_ff;
   logic [XW-1:0]              rvar_ff, cvar_ff, xvar_ff;
   logic                       empty_ff;
   logic                       out_full_ff;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = (CW+1)'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = (CW+1)'(MAX_WIDTH);
      end else begin
         eff_w = (CW+1)'(width_ff);
      end
   end

   assign obj = (pixel == '0) && (32'(area_ff) < 32'(AREA_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bme_pkg::WIDTH_RESET;
      end else if (csr_valid) begin
         width_ff <= csr_image_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         col_ff  <= '0;
         row_ff  <= '0;
         area_ff <= '0;
         rs_ff   <= '0;
         cs_ff   <= '0;
         rsq_ff  <= '0;
         csq_ff  <= '0;
         xs_ff   <= '0;
      end else if (cmd.accum) begin
         if (obj) begin
            area_ff <= area_ff + 1'b1;
            rs_ff   <= rs_ff + RSW'(row_ff);
            cs_ff   <= cs_ff + CSW'(col_ff);
            rsq_ff  <= rsq_ff + (AW+2*RW)'(row_ff * row_ff);
            csq_ff  <= csq_ff + (AW+2*CW)'(col_ff * col_ff);
            xs_ff   <= xs_ff + (AW+RW+CW)'(row_ff * col_ff);
         end
         if ((CW+1)'(col_ff) + 1'b1 >= eff_w) begin
            col_ff <= '0;
            if (32'(row_ff) < 32'(MAX_HEIGHT - 1)) begin
               row_ff <= row_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Operand selection for the product and the dividend.
   always_comb begin
      a_op = (cmd.op == bme_pkg::OP_CVAR) ? SW'(cs_ff) : SW'(rs_ff);
      b_op = (cmd.op == bme_pkg::OP_RVAR) ? SW'(rs_ff) : SW'(cs_ff);
      unique case (cmd.op)
         bme_pkg::OP_CROW: dividend = DW'({rs_ff, 8'h00});
         bme_pkg::OP_CCOL: dividend = DW'({cs_ff, 8'h00});
         default:          dividend = {prod_ff, 8'h00};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= a_op * b_op;
      end
   end

   bme_divider #(.DW(DW), .VW(AW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (area_ff),
      .done     (div_done),
      .quotient (quot),
      .rem_nz   (rem_nz)
   );

   // Central moment: 256*sum_sq minus the rounded-up mean product.
   always_comb begin
      unique case (cmd.op)
         bme_pkg::OP_RVAR: base = XW'({rsq_ff, 8'h00});
         bme_pkg::OP_CVAR: base = XW'({csq_ff, 8'h00});
         default:          base = XW'({xs_ff, 8'h00});
      endcase
      ceilq = XW'(quot) + XW'(rem_nz);
      diff  = base - ceilq;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_empty) begin
         crow_ff  <= '0;
         ccol_ff  <= '0;
         rvar_ff  <= '0;
         cvar_ff  <= '0;
         xvar_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.store) begin
         empty_ff <= 1'b0;
         unique case (cmd.op)
            bme_pkg::OP_CROW: crow_ff <= quot[bme_pkg::CENT_W-1:0];
            bme_pkg::OP_CCOL: ccol_ff <= quot[bme_pkg::CENT_W-1:0];
            bme_pkg::OP_RVAR: rvar_ff <= diff;
            bme_pkg::OP_CVAR: cvar_ff <= diff;
            default:          xvar_ff <= diff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_full_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_full_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_area             <= bme_pkg::AREA_W'(area_ff);
         rsp_centroid_row_q8  <= crow_ff;
         rsp_centroid_col_q8  <= ccol_ff;
         rsp_row_central_q8   <= rvar_ff[bme_pkg::VAR_W-1:0];
         rsp_col_central_q8   <= cvar_ff[bme_pkg::VAR_W-1:0];
         rsp_cross_central_q8 <= xvar_ff;
         rsp_empty_blob       <= empty_ff;
      end
   end

   assign rsp_valid     = out_full_ff;
   assign sts.area_zero = (area_ff == '0);
   assign sts.div_done  = div_done;
   assign sts.out_full  = out_full_ff;

endmodule

// ===== rtl/bme_ctrl.sv =====
module bme_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_end_of_frame,
   output logic             req_ready,
   input  bme_pkg::sts_type sts,
   output bme_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL,
      S_DIVGO,
      S_DIVWAIT,
      S_OUT
   } state_type;

   state_type       state_ff, state_in;
   bme_pkg::op_type op_ff, op_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_end_of_frame) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            op_in = bme_pkg::OP_CROW;
            if (sts.area_zero) begin
               cmd.store_empty = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (sts.div_done) begin
               cmd.store = 1'b1;
               if (op_ff == bme_pkg::OP_XVAR) begin
                  state_in = S_OUT;
               end else begin
                  op_in    = bme_pkg::op_type'(op_ff + 3'd1);
                  state_in = S_MUL;
               end
            end
         end
         S_OUT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= bme_pkg::OP_CROW;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

// ===== rtl/blob_moment_engine.sv =====
// Blob moment engine: area, centroid and central second moments of the
// zero-valued pixels of a raster-order image.
// Pixels arrive on the req_ channel, one transfer per cycle while the block
// is gathering; the transfer that carries req_end_of_frame closes the frame.
// The column counter wraps at the width held in the csr_ register (written
// with a csr_ transfer, always ready; zero acts as one, values above
// MAX_WIDTH act as MAX_WIDTH). The row counter saturates at MAX_HEIGHT-1.
// After the end-of-frame transfer the block runs five divisions in turn on
// one shared restoring divider, one quotient bit per cycle, each over a
// dividend of 2*S + 8 bits, where S is the widest coordinate sum (31 bits at
// the default sizes); an empty frame skips them and goes from the area check
// to the output load. Meanwhile req_ready is low.
// The result sits in an output register and is offered on rsp_ with
// rsp_valid; pixels of the next frame are taken while it waits. If the
// receiver stalls past the next frame end, the block holds that result and
// stops taking pixels until the previous one is transferred.
// Synchronous reset clears all sums and counters, drops rsp_valid and sets
// the width register to 1024.
module blob_moment_engine #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bme_pkg::PIX_W-1:0]         req_pixel,
   input  logic                              req_end_of_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bme_pkg::AREA_W-1:0]        rsp_area,
   output logic [bme_pkg::CENT_W-1:0]        rsp_centroid_row_q8,
   output logic [bme_pkg::CENT_W-1:0]        rsp_centroid_col_q8,
   output logic [bme_pkg::VAR_W-1:0]         rsp_row_central_q8,
   output logic [bme_pkg::VAR_W-1:0]         rsp_col_central_q8,
   output logic signed [bme_pkg::XVAR_W-1:0] rsp_cross_central_q8,
   output logic                              rsp_empty_blob,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bme_pkg::CFG_W-1:0]         csr_image_width
);

   bme_pkg::cmd_type cmd;
   bme_pkg::sts_type sts;

   // The width register takes a write in any cycle.
   assign csr_ready = 1'b1;

   bme_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_frame (req_end_of_frame),
      .req_ready        (req_ready),
      .sts              (sts),
      .cmd              (cmd)
   );

   bme_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .pixel                (req_pixel),
      .csr_valid            (csr_valid),
      .csr_image_width      (csr_image_width),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_area             (rsp_area),
      .rsp_centroid_row_q8  (rsp_centroid_row_q8),
      .rsp_centroid_col_q8  (rsp_centroid_col_q8),
      .rsp_row_central_q8   (rsp_row_central_q8),
      .rsp_col_central_q8   (rsp_col_central_q8),
      .rsp_cross_central_q8 (rsp_cross_central_q8),
      .rsp_empty_blob       (rsp_empty_blob)
   );

endmodule

// ===== verif/tb_blob_moment_engine.sv =====
module tb_blob_moment_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_W  = bme_pkg::PIX_W;
   localparam int CFG_W  = bme_pkg::CFG_W;
   localparam int AREA_W = bme_pkg::AREA_W;
   localparam int CENT_W = bme_pkg::CENT_W;
   localparam int VAR_W  = bme_pkg::VAR_W;
   localparam int XVAR_W = bme_pkg::XVAR_W;

   // The run is stopped by force if it has not finished within this
   // many clock cycles.
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_W       = 1024;
   localparam int MAX_H       = 1024;
   localparam int IMAGE_PIXELS = MAX_W * MAX_H;

   // One set of frame moments, as the block reports them on the rsp_ side.
   typedef struct {
      logic [AREA_W-1:0]        area;
      logic [CENT_W-1:0]        crow;
      logic [CENT_W-1:0]        ccol;
      logic [VAR_W-1:0]         rvar;
      logic [VAR_W-1:0]         cvar;
      logic signed [XVAR_W-1:0] xvar;
      logic                     empty;
   } moments_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel;
   logic                     req_end_of_frame;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [AREA_W-1:0]        rsp_area;
   logic [CENT_W-1:0]        rsp_centroid_row_q8;
   logic [CENT_W-1:0]        rsp_centroid_col_q8;
   logic [VAR_W-1:0]         rsp_row_central_q8;
   logic [VAR_W-1:0]         rsp_col_central_q8;
   logic signed [XVAR_W-1:0] rsp_cross_central_q8;
   logic                     rsp_empty_blob;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CFG_W-1:0]         csr_image_width;

   blob_moment_engine u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_pixel            (req_pixel),
      .req_end_of_frame     (req_end_of_frame),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_area             (rsp_area),
      .rsp_centroid_row_q8  (rsp_centroid_row_q8),
      .rsp_centroid_col_q8  (rsp_centroid_col_q8),
      .rsp_row_central_q8   (rsp_row_central_q8),
      .rsp_col_central_q8   (rsp_col_central_q8),
      .rsp_cross_central_q8 (rsp_cross_central_q8),
      .rsp_empty_blob       (rsp_empty_blob),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_image_width      (csr_image_width)
   );

   // Our own copy of the block's state: the width register, the raster
   // position and the exact moment sums of the frame being gathered.
   logic [CFG_W-1:0] width_reg;
   int unsigned      col_pos, row_pos;
   longint unsigned  area_acc, row_acc, col_acc, row_sq_acc, col_sq_acc, cross_acc;

   moments_type pending_moments[$];
   int       mismatches = 0;
   int       frames_checked = 0;
   int       empty_frames = 0;
   int       pixels_sent;
   int       cycle_count = 0;
   int       stall_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver refuses a transfer with a probability that the tests set;
   // zero gives stretches in which every result is taken at once.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_moments.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void clear_frame_sums();
      col_pos    = 0;
      row_pos    = 0;
      area_acc   = 0;
      row_acc    = 0;
      col_acc    = 0;
      row_sq_acc = 0;
      col_sq_acc = 0;
      cross_acc  = 0;
   endfunction

   // floor(256*(sq*n - a*b)/n) is 256*sq - ceil(256*a*b/n); the products are
   // formed at 128 bits so that nothing is lost before the final truncation.
   function automatic logic [127:0] central_q8(longint unsigned sq, longint unsigned a,
                                               longint unsigned b, longint unsigned n);
      logic [127:0] prod;
      logic [127:0] ceil_q;
      prod   = 128'(a) * 128'(b) * 128'd256;
      ceil_q = (prod + 128'(n) - 128'd1) / 128'(n);
      return (128'(sq) << 8) - ceil_q;
   endfunction

   // Accounts for one accepted pixel and, at the end of a frame, queues the
   // moments that the block must report.
   function automatic void account_pixel(logic [PIX_W-1:0] pix, logic eof);
      int unsigned eff_w;
      moments_type m;
      logic [127:0] wide;
      eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      if (pix == 0 && area_acc < IMAGE_PIXELS) begin
         area_acc   += 1;
         row_acc    += row_pos;
         col_acc    += col_pos;
         row_sq_acc += longint'(row_pos) * row_pos;
         col_sq_acc += longint'(col_pos) * col_pos;
         cross_acc  += longint'(row_pos) * col_pos;
      end
      if (col_pos + 1 >= eff_w) begin
         col_pos = 0;
         if (row_pos < MAX_H - 1) row_pos++;
      end else begin
         col_pos++;
      end
      if (!eof) return;
      if (area_acc == 0) begin
         m = '{area: '0, crow: '0, ccol: '0, rvar: '0, cvar: '0, xvar: '0, empty: 1'b1};
      end else begin
         m.area  = area_acc[AREA_W-1:0];
         wide    = (128'(row_acc) << 8) / 128'(area_acc);
         m.crow  = wide[CENT_W-1:0];
         wide    = (128'(col_acc) << 8) / 128'(area_acc);
         m.ccol  = wide[CENT_W-1:0];
         wide    = central_q8(row_sq_acc, row_acc, row_acc, area_acc);
         m.rvar  = wide[VAR_W-1:0];
         wide    = central_q8(col_sq_acc, col_acc, col_acc, area_acc);
         m.cvar  = wide[VAR_W-1:0];
         wide    = central_q8(cross_acc, row_acc, col_acc, area_acc);
         m.xvar  = wide[XVAR_W-1:0];
         m.empty = 1'b0;
      end
      pending_moments.push_back(m);
      clear_frame_sums();
   endfunction

   function automatic void report_field(string name, logic [63:0] expv, logic [63:0] actv);
      if (expv !== actv) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s at frame %0d: expected 0x%0h, got 0x%0h", name,
                     frames_checked, expv, actv);
      end
   endfunction

   // Every rsp_ transfer is compared with the oldest queued set of moments.
   always @(posedge clock) begin
      moments_type m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_moments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result transfer with no frame outstanding");
         end else begin
            m = pending_moments.pop_front();
            report_field("area", 64'(m.area), 64'(rsp_area));
            report_field("centroid_row", 64'(m.crow), 64'(rsp_centroid_row_q8));
            report_field("centroid_col", 64'(m.ccol), 64'(rsp_centroid_col_q8));
            report_field("row_central", 64'(m.rvar), 64'(rsp_row_central_q8));
            report_field("col_central", 64'(m.cvar), 64'(rsp_col_central_q8));
            report_field("cross_central", 64'(unsigned'(m.xvar)),
                         64'(unsigned'(rsp_cross_central_q8)));
            report_field("empty_blob", 64'(m.empty), 64'(rsp_empty_blob));
            if (m.empty) empty_frames++;
            frames_checked++;
         end
      end
   end

   // All drivers below are entered just after a falling edge and return just
   // after one, so every input changes at the falling edge only.
   task automatic send_pixel(logic [PIX_W-1:0] pix, logic eof);
      req_valid        <= 1'b1;
      req_pixel        <= pix;
      req_end_of_frame <= eof;
      do @(posedge clock); while (!req_ready);
      account_pixel(pix, eof);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Drops req_valid for a number of cycles; a zero gap keeps the burst going.
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      idle_sender(1);
      while (pending_moments.size() != 0) @(negedge clock);
      // A pixel without end of frame leaves nothing to wait for; the block is
      // given time to settle before the next test.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_width(logic [CFG_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_image_width <= value;
      do @(posedge clock); while (!csr_ready);
      width_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sends one frame of the given length with a fraction of object pixels,
   // in bursts of random length with random gaps.
   task automatic send_frame(int len, int zero_pct, int max_gap);
      int burst;
      logic [PIX_W-1:0] pix;
      burst = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
         pix = ($urandom_range(99) < zero_pct) ? '0 : PIX_W'($urandom_range(255, 1));
         send_pixel(pix, i == len - 1);
         if (--burst == 0) begin
            idle_sender($urandom_range(max_gap));
            burst = $urandom_range(8, 1);
         end
      end
   endtask

   // Reset width of 1024 with the extreme grey values and both flag values.
   task automatic test_default_width();
      stall_pct = 0;
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd0, 1'b1);
      wait_drained();
   endtask

   // Frames without an object pixel must give zeros and the flag; the last frame has one.
   task automatic test_empty_frames();
      stall_pct = 40;
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd0, 1'b1);
      wait_drained();
   endtask

   // Widths of zero and above the maximum are clamped; the limits themselves.
   task automatic test_width_extremes();
      logic [CFG_W-1:0] widths[5] = '{11'd0, 11'd2047, 11'd1025, 11'd1, 11'd1024};
      foreach (widths[i]) begin
         write_width(widths[i]);
         send_frame(4, 75, 2);
         wait_drained();
      end
   endtask

   // The width is narrowed while the column counter sits past the new width.
   task automatic test_width_change_midrow();
      write_width(11'd6);
      for (int i = 0; i < 5; i++) send_pixel(8'd0, 1'b0);
      wait_drained();
      write_width(11'd3);
      for (int i = 0; i < 6; i++) send_pixel(8'd0, i == 5);
      wait_drained();
   endtask

   // A one-pixel-wide image taller than the row counter can follow.
   task automatic test_row_saturation();
      write_width(11'd1);
      stall_pct = 0;
      for (int i = 0; i < MAX_H + 12; i++)
         send_pixel((i % 3 == 1) ? 8'd255 : 8'd0, i == MAX_H + 11);
      wait_drained();
   endtask

   // Random widths and frames. Most widths are small so that frames wrap
   // over several rows; now and then a wide or out-of-range width is used.
   task automatic test_random_frames(int pixel_budget);
      int sent_here;
      int sel;
      sent_here = 0;
      while (sent_here < pixel_budget) begin
         sel = $urandom_range(99);
         if (sel < 70)      write_width(CFG_W'($urandom_range(12, 1)));
         else if (sel < 90) write_width(CFG_W'($urandom_range(2047)));
         stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(85);
         for (int f = $urandom_range(6, 1); f > 0; f--) begin
            sel = $urandom_range(40, 1);
            send_frame(sel, $urandom_range(100), $urandom_range(6));
            sent_here += sel;
         end
         // The sender holds back until every result of this phase is in.
         wait_drained();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel        = '0;
      req_end_of_frame = 1'b0;
      csr_valid        = 1'b0;
      csr_image_width  = '0;
      width_reg        = bme_pkg::WIDTH_RESET;
      pixels_sent      = 0;
      stall_pct        = 0;
      clear_frame_sums();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_width();
      test_empty_frames();
      test_width_extremes();
      test_width_change_midrow();
      test_row_saturation();
      test_random_frames(570);

      idle_sender(1);
      while (pending_moments.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Checked %0d frames (%0d empty) from %0d pixel transfers,", frames_checked,
               empty_frames, pixels_sent);
      $display("over clamped, small and full widths and a saturated row counter.");
      if (mismatches == 0 && pending_moments.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_moments.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bme_pkg.sv
rtl/bme_divider.sv
rtl/bme_datapath.sv
rtl/bme_ctrl.sv
rtl/blob_moment_engine.sv
verif/tb_blob_moment_engine.sv
